// File: src/rrts_pkg.sv
`default_nettype none
package rrts_pkg;

   localparam int MAX_TASKS = 16;
   localparam int TIME_BITS = 32;
   localparam int ADDR_BITS = 32;
   localparam int IDX_BITS = $clog2(MAX_TASKS);
   localparam int CNT_BITS = $clog2(MAX_TASKS + 1);
   localparam logic [CNT_BITS-1:0] RUN_NONE = CNT_BITS'(MAX_TASKS);

   typedef enum logic [2:0] {
      KIND_SCHEDULE = 3'd0,
      KIND_WAIT     = 3'd1,
      KIND_WAKE_ONE = 3'd2,
      KIND_WAKE_ALL = 3'd3,
      KIND_SLEEP    = 3'd4,
      KIND_EXIT     = 3'd5,
      KIND_EXIT_ALL = 3'd6,
      KIND_NONE     = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_RUN      = 3'd0,
      ST_IDLE     = 3'd1,
      ST_ALL_EXIT = 3'd2,
      ST_DEADLOCK = 3'd3,
      ST_ACCEPTED = 3'd4,
      ST_MISMATCH = 3'd5,
      ST_WOKE     = 3'd6,
      ST_NONE     = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DONE,
      FSM_HOLD
   } fsm_type;

   // controller to datapath
   typedef struct packed {
      logic     load;     // capture request word, start scan
      logic     step;     // examine one entry
      logic     finish;   // commit result
      kind_type kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;         // current entry is the last one to examine
      logic stop;         // current entry ends the scan
   } stat_type;

endpackage
`default_nettype wire

// File: src/round_robin_task_scheduler_unit.sv
`default_nettype none
// Round-robin task scheduler: each request word is one kernel event and yields one response
// word. Events that touch a single entry (wait, sleep, exit, unknown) pass from acceptance
// to a commit state and then to the response; schedule, wake and exit-all first walk the
// task table one entry per cycle, over up to num_tasks entries (at most 16; 0 counts as 1).
// One event is in flight at a time; a new request is taken once its response has been taken.
module round_robin_task_scheduler_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [4:0]         csr_num_tasks,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_kind,
   input  wire logic [31:0]        req_now,
   input  wire logic [31:0]        req_wait_address,
   input  wire logic signed [31:0] req_expected_value,
   input  wire logic signed [31:0] req_observed_value,
   input  wire logic [31:0]        req_timeout_ticks,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [3:0]              rsp_task_index,
   output logic [31:0]             rsp_wait_ticks,
   output logic                    rsp_timed_out
);
   rrts_pkg::cmd_type  cmd;
   rrts_pkg::stat_type stat;

   rrts_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind,
      .rsp_valid, .rsp_stall, .cmd, .stat
   );

   rrts_dp u_dp (
      .clock, .reset, .csr_valid, .csr_ready, .csr_num_tasks,
      .req_now, .req_wait_address, .req_expected_value, .req_observed_value,
      .req_timeout_ticks, .cmd, .stat,
      .rsp_status, .rsp_task_index, .rsp_wait_ticks, .rsp_timed_out
   );
endmodule
`default_nettype wire

// File: src/rrts_ctrl.sv
`default_nettype none
module rrts_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_kind,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rrts_pkg::cmd_type      cmd,
   input  wire rrts_pkg::stat_type stat
);

   rrts_pkg::fsm_type  state_ff, state_in;
   rrts_pkg::kind_type kind_ff, kind_in;
   logic               is_scan;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrts_pkg::FSM_IDLE;
         kind_ff  <= rrts_pkg::KIND_NONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   assign is_scan = (rrts_pkg::kind_type'(req_kind) inside {rrts_pkg::KIND_SCHEDULE,
                     rrts_pkg::KIND_WAKE_ONE, rrts_pkg::KIND_WAKE_ALL,
                     rrts_pkg::KIND_EXIT_ALL});

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      cmd.kind   = kind_ff;
      case (state_ff)
         rrts_pkg::FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cmd.kind = rrts_pkg::kind_type'(req_kind);
               kind_in  = rrts_pkg::kind_type'(req_kind);
               state_in = is_scan ? rrts_pkg::FSM_SCAN : rrts_pkg::FSM_DONE;
            end
         end
         rrts_pkg::FSM_SCAN: begin
            cmd.step = 1'b1;
            if (stat.last || stat.stop) state_in = rrts_pkg::FSM_DONE;
         end
         rrts_pkg::FSM_DONE: begin
            cmd.finish = 1'b1;
            state_in   = rrts_pkg::FSM_HOLD;
         end
         rrts_pkg::FSM_HOLD: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = rrts_pkg::FSM_IDLE;
         end
         default: state_in = rrts_pkg::FSM_IDLE;
      endcase
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rrts_pkg::FSM_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_done_to_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrts_pkg::FSM_DONE) |=> (state_ff == rrts_pkg::FSM_HOLD))
      else $error("result not presented after commit");
   a_hold_stays: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule
`default_nettype wire

// File: src/rrts_dp.sv
`default_nettype none
module rrts_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [4:0]                     csr_num_tasks,
   input  wire logic [31:0]                    req_now,
   input  wire logic [31:0]                    req_wait_address,
   input  wire logic signed [31:0]             req_expected_value,
   input  wire logic signed [31:0]             req_observed_value,
   input  wire logic [31:0]                    req_timeout_ticks,
   input  wire rrts_pkg::cmd_type              cmd,
   output rrts_pkg::stat_type                  stat,
   output logic [2:0]                          rsp_status,
   output logic [3:0]                          rsp_task_index,
   output logic [31:0]                         rsp_wait_ticks,
   output logic                                rsp_timed_out
);
   localparam int IB = rrts_pkg::IDX_BITS;
   localparam int CB = rrts_pkg::CNT_BITS;
   localparam int TB = rrts_pkg::TIME_BITS;
   localparam int AB = rrts_pkg::ADDR_BITS;
   localparam int MT = rrts_pkg::MAX_TASKS;

   logic [4:0]    num_ff;
   logic [MT-1:0] exited_ff, blocked_ff;
   logic [AB-1:0] addr_mem [MT];
   logic [TB-1:0] dl_ff [MT];
   logic [CB-1:0] run_ff;
   logic [CB-1:0] n;
   logic          run_ok;

   // request word copy
   logic [TB-1:0] now_ff, sum_ff;
   logic [AB-1:0] waddr_ff;
   logic          match_ff, tmo_nz_ff;

   // scan state
   logic [IB-1:0] cur_ff, first;
   logic [CB-1:0] cnt_ff, nexit_ff;
   logic [TB-1:0] early_ff;
   logic          chosen_ff, woke_ff, tout_ff;
   logic [IB-1:0] pick_ff;

   // result registers
   logic [2:0]    status_ff;
   logic [3:0]    index_ff;
   logic [31:0]   wticks_ff;
   logic          timed_ff;

   assign csr_ready = 1'b1;
   assign n = (num_ff == 5'd0) ? CB'(1) :
              ({27'd0, num_ff} > MT) ? CB'(MT) : CB'(num_ff);
   assign run_ok = run_ff < n;
   assign first = (run_ok && (run_ff + CB'(1) < n)) ? IB'(run_ff + CB'(1)) : '0;

   // one entry per cycle
   logic [TB-1:0] dl_c;
   logic          ex_c, bl_c, due_c, pick_c, wake_c;
   logic [TB:0]   sum_w;
   assign dl_c   = dl_ff[cur_ff];
   assign ex_c   = exited_ff[cur_ff];
   assign bl_c   = blocked_ff[cur_ff];
   assign due_c  = (dl_c != '0) && (now_ff > dl_c);
   assign pick_c = !ex_c && (due_c || ((dl_c == '0) && !bl_c));
   assign wake_c = bl_c && (addr_mem[cur_ff] == waddr_ff);
   assign stat.last = (cnt_ff + CB'(1) >= n);
   assign stat.stop = (cmd.kind == rrts_pkg::KIND_SCHEDULE) ? pick_c :
                      (cmd.kind == rrts_pkg::KIND_WAKE_ONE) ? wake_c : 1'b0;
   assign sum_w = {1'b0, req_now} + {1'b0, req_timeout_ticks};

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff     <= 5'd1;
         exited_ff  <= '0;
         blocked_ff <= '0;
         run_ff     <= rrts_pkg::RUN_NONE;
         for (int i = 0; i < MT; i++) dl_ff[i] <= '0;
      end else begin
         if (csr_valid) num_ff <= csr_num_tasks;
         // capture request
         if (cmd.load) begin
            now_ff    <= req_now;
            waddr_ff  <= req_wait_address;
            match_ff  <= (req_expected_value == req_observed_value);
            tmo_nz_ff <= (req_timeout_ticks != '0);
            sum_ff    <= sum_w[TB] ? '1 : sum_w[TB-1:0];
            cur_ff    <= (cmd.kind == rrts_pkg::KIND_SCHEDULE) ? first : '0;
            cnt_ff    <= '0;
            nexit_ff  <= '0;
            early_ff  <= '0;
            chosen_ff <= 1'b0;
            woke_ff   <= 1'b0;
            tout_ff   <= 1'b0;
            pick_ff   <= '0;
         end
         // scan step
         if (cmd.step) begin
            cnt_ff <= cnt_ff + CB'(1);
            cur_ff <= (CB'(cur_ff) + CB'(1) >= n) ? '0 : cur_ff + IB'(1);
            case (cmd.kind)
               rrts_pkg::KIND_SCHEDULE: begin
                  if (ex_c) nexit_ff <= nexit_ff + CB'(1);
                  else if (dl_c != '0 && (early_ff == '0 || early_ff > dl_c))
                     early_ff <= dl_c;
                  if (pick_c) begin
                     chosen_ff <= 1'b1;
                     pick_ff   <= cur_ff;
                     tout_ff   <= due_c && bl_c;
                     if (due_c) blocked_ff[cur_ff] <= 1'b0;
                     dl_ff[cur_ff] <= '0;
                  end
               end
               rrts_pkg::KIND_WAKE_ONE, rrts_pkg::KIND_WAKE_ALL: begin
                  if (wake_c) begin
                     blocked_ff[cur_ff] <= 1'b0;
                     dl_ff[cur_ff]      <= '0;
                     woke_ff            <= 1'b1;
                  end
               end
               rrts_pkg::KIND_EXIT_ALL: exited_ff[cur_ff] <= 1'b1;
               default: ;
            endcase
         end
         // commit
         if (cmd.finish) begin
            status_ff <= rrts_pkg::ST_ACCEPTED;
            index_ff  <= '0;
            wticks_ff <= '0;
            timed_ff  <= 1'b0;
            case (cmd.kind)
               rrts_pkg::KIND_SCHEDULE: begin
                  if (chosen_ff) begin
                     status_ff <= rrts_pkg::ST_RUN;
                     index_ff  <= 4'(pick_ff);
                     timed_ff  <= tout_ff;
                     run_ff    <= CB'(pick_ff);
                  end else begin
                     run_ff <= rrts_pkg::RUN_NONE;
                     if (nexit_ff == n) status_ff <= rrts_pkg::ST_ALL_EXIT;
                     else if (early_ff == '0) status_ff <= rrts_pkg::ST_DEADLOCK;
                     else begin
                        status_ff <= rrts_pkg::ST_IDLE;
                        wticks_ff <= 32'(early_ff - now_ff);
                     end
                  end
               end
               rrts_pkg::KIND_WAIT: begin
                  if (!match_ff) status_ff <= rrts_pkg::ST_MISMATCH;
                  else if (run_ok) begin
                     blocked_ff[IB'(run_ff)] <= 1'b1;
                     if (tmo_nz_ff) dl_ff[IB'(run_ff)] <= sum_ff;
                  end
               end
               rrts_pkg::KIND_WAKE_ONE, rrts_pkg::KIND_WAKE_ALL:
                  status_ff <= woke_ff ? rrts_pkg::ST_WOKE : rrts_pkg::ST_NONE;
               rrts_pkg::KIND_SLEEP:
                  if (run_ok) dl_ff[IB'(run_ff)] <= sum_ff;
               rrts_pkg::KIND_EXIT:
                  if (run_ok) exited_ff[IB'(run_ff)] <= 1'b1;
               default: ;
            endcase
         end
      end
   end

   // wait address store, no reset
   always_ff @(posedge clock) begin
      if (cmd.finish && cmd.kind == rrts_pkg::KIND_WAIT && match_ff && run_ok)
         addr_mem[IB'(run_ff)] <= waddr_ff;
   end

   assign rsp_status     = status_ff;
   assign rsp_task_index = index_ff;
   assign rsp_wait_ticks = wticks_ff;
   assign rsp_timed_out  = timed_ff;

   a_run_in_range: assert property (@(posedge clock) disable iff (reset)
      (run_ff <= rrts_pkg::RUN_NONE))
      else $error("running task code out of range");
   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (cnt_ff < n))
      else $error("scan ran past entries in use");
   a_timeout_with_run: assert property (@(posedge clock) disable iff (reset)
      timed_ff |-> (status_ff == rrts_pkg::ST_RUN))
      else $error("timeout flag without a run result");

endmodule
`default_nettype wire

// File: verif/round_robin_task_scheduler_unit_tb.sv
`timescale 1ns / 1ps
module round_robin_task_scheduler_unit_tb;
   import rrts_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [3:0]  index;
      logic [31:0] ticks;
      logic        timed_out;
   } sched_rsp_t;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] now;
      logic [31:0] addr;
      logic [31:0] expv;
      logic [31:0] obsv;
      logic [31:0] tmo;
      logic        pinned;
      sched_rsp_t  rsp;
   } event_row_t;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_num_tasks = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   kind_type req_kind = KIND_SCHEDULE;
   logic [31:0] req_now = '0;
   logic [31:0] req_wait_address = '0;
   logic signed [31:0] req_expected_value = '0;
   logic signed [31:0] req_observed_value = '0;
   logic [31:0] req_timeout_ticks = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [3:0] rsp_task_index;
   logic [31:0] rsp_wait_ticks;
   logic rsp_timed_out;

   // typed-in expectation riding along with the request word
   logic req_pinned = 1'b0;
   sched_rsp_t req_pinned_rsp = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int quiet_cycles = 0;
   logic [31:0] time_base = '0;

   // scheduler shadow state
   logic [4:0] sh_num_tasks;
   logic sh_exited [MAX_TASKS];
   logic sh_blocked [MAX_TASKS];
   logic [31:0] sh_addr [MAX_TASKS];
   logic [31:0] sh_deadline [MAX_TASKS];
   int unsigned sh_running;

   sched_rsp_t pending_rsp [$];

   round_robin_task_scheduler_unit DUT (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_num_tasks(csr_num_tasks),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_now(req_now), .req_wait_address(req_wait_address),
      .req_expected_value(req_expected_value), .req_observed_value(req_observed_value),
      .req_timeout_ticks(req_timeout_ticks),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_task_index(rsp_task_index), .rsp_wait_ticks(rsp_wait_ticks),
      .rsp_timed_out(rsp_timed_out)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] deadline_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // apply one kernel event to the shadow table and return its response
   function automatic sched_rsp_t schedule_event(kind_type kind, logic [31:0] now,
         logic [31:0] addr, logic [31:0] expv, logic [31:0] obsv, logic [31:0] tmo);
      sched_rsp_t r;
      int unsigned n, first, c, nexited;
      logic [31:0] earliest;
      logic chosen, run_ok;
      n = (sh_num_tasks == 0) ? 1 : (sh_num_tasks > MAX_TASKS) ? MAX_TASKS : sh_num_tasks;
      run_ok = sh_running < n;
      r = '{ST_ACCEPTED, 4'd0, 32'd0, 1'b0};
      case (kind)
         KIND_SCHEDULE: begin
            first = (run_ok && sh_running + 1 < n) ? sh_running + 1 : 0;
            nexited = 0;
            earliest = '0;
            chosen = 1'b0;
            for (int k = 0; k < n && !chosen; k++) begin
               c = first + k;
               if (c >= n) c -= n;
               if (sh_exited[c]) begin
                  nexited++;
               end else if (sh_deadline[c] != 0) begin
                  if (earliest == 0 || earliest > sh_deadline[c]) earliest = sh_deadline[c];
                  if (now > sh_deadline[c]) begin
                     chosen = 1'b1;
                     r.index = c[3:0];
                     if (sh_blocked[c]) begin
                        sh_blocked[c] = 1'b0;
                        r.timed_out = 1'b1;
                     end
                  end
               end else if (!sh_blocked[c]) begin
                  chosen = 1'b1;
                  r.index = c[3:0];
               end
            end
            if (chosen) begin
               r.status = ST_RUN;
               sh_running = r.index;
               sh_deadline[r.index] = '0;
            end else begin
               sh_running = MAX_TASKS;
               if (nexited == n) r.status = ST_ALL_EXIT;
               else if (earliest == 0) r.status = ST_DEADLOCK;
               else begin
                  r.status = ST_IDLE;
                  r.ticks = earliest - now;
               end
            end
         end
         KIND_WAIT: begin
            if (expv != obsv) r.status = ST_MISMATCH;
            else if (run_ok) begin
               sh_blocked[sh_running] = 1'b1;
               sh_addr[sh_running] = addr;
               if (tmo != 0) sh_deadline[sh_running] = deadline_sum(now, tmo);
            end
         end
         KIND_WAKE_ONE, KIND_WAKE_ALL: begin
            r.status = ST_NONE;
            for (int i = 0; i < n; i++) begin
               if (sh_blocked[i] && sh_addr[i] == addr &&
                     !(kind == KIND_WAKE_ONE && r.status == ST_WOKE)) begin
                  sh_blocked[i] = 1'b0;
                  sh_deadline[i] = '0;
                  r.status = ST_WOKE;
               end
            end
         end
         KIND_SLEEP: if (run_ok) sh_deadline[sh_running] = deadline_sum(now, tmo);
         KIND_EXIT: if (run_ok) sh_exited[sh_running] = 1'b1;
         KIND_EXIT_ALL: for (int i = 0; i < n; i++) sh_exited[i] = 1'b1;
         default: ;
      endcase
      return r;
   endfunction

   // accept tracking, response checking, watchdog
   always @(posedge clock) begin
      sched_rsp_t want, got;
      if (reset) begin
         sh_num_tasks = 5'd1;
         sh_running = MAX_TASKS;
         for (int i = 0; i < MAX_TASKS; i++) begin
            sh_exited[i] = 1'b0;
            sh_blocked[i] = 1'b0;
            sh_addr[i] = '0;
            sh_deadline[i] = '0;
         end
      end else begin
         quiet_cycles++;
         if (csr_valid && csr_ready) begin
            sh_num_tasks = csr_num_tasks;
            quiet_cycles = 0;
         end
         if (req_valid && !req_stall) begin
            want = schedule_event(req_kind, req_now, req_wait_address, req_expected_value,
                                  req_observed_value, req_timeout_ticks);
            pending_rsp.push_back(req_pinned ? req_pinned_rsp : want);
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            got = '{status_type'(rsp_status), rsp_task_index, rsp_wait_ticks, rsp_timed_out};
            if (pending_rsp.size() == 0) begin
               $error("response word with nothing expected: status %0d", rsp_status);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (got.status != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  errors++;
               end
               if (got.index != want.index) begin
                  $error("task_index: expected %0d, got %0d", want.index, got.index);
                  errors++;
               end
               if (got.ticks != want.ticks) begin
                  $error("wait_ticks: expected %0d, got %0d", want.ticks, got.ticks);
                  errors++;
               end
               if (got.timed_out != want.timed_out) begin
                  $error("timed_out: expected %0d, got %0d", want.timed_out, got.timed_out);
                  errors++;
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   task automatic send_event(event_row_t row);
      req_valid <= 1'b1;
      req_kind <= row.kind;
      req_now <= row.now;
      req_wait_address <= row.addr;
      req_expected_value <= row.expv;
      req_observed_value <= row.obsv;
      req_timeout_ticks <= row.tmo;
      req_pinned <= row.pinned;
      req_pinned_rsp <= row.rsp;
      do @(posedge clock); while (req_stall);
      // sender gaps between words
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_queue();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_num_tasks(logic [4:0] value);
      drain_queue();
      csr_valid <= 1'b1;
      csr_num_tasks <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic event_row_t random_event();
      event_row_t e;
      int pick;
      logic [31:0] pool [4] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'hA5A5_0000};
      e = '0;
      pick = $urandom_range(0, 999);
      if (pick < 380) e.kind = KIND_SCHEDULE;
      else if (pick < 580) e.kind = KIND_WAIT;
      else if (pick < 680) e.kind = KIND_WAKE_ONE;
      else if (pick < 760) e.kind = KIND_WAKE_ALL;
      else if (pick < 950) e.kind = KIND_SLEEP;
      else if (pick < 955) e.kind = KIND_EXIT;
      else e.kind = KIND_NONE;
      // mostly a slowly advancing clock so that deadlines come due
      if ($urandom_range(0, 9) != 0) begin
         time_base = time_base + $urandom_range(0, 20);
         e.now = time_base;
      end else begin
         e.now = $urandom;
      end
      pick = $urandom_range(0, 9);
      e.tmo = (pick < 7) ? $urandom_range(1, 40) : (pick == 7) ? 32'd0 : $urandom;
      e.addr = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 3)] : $urandom;
      e.expv = $urandom;
      e.obsv = ($urandom_range(0, 99) < 80) ? e.expv : $urandom;
      return e;
   endfunction

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) send_event(random_event());
   endtask

   event_row_t directed [] = '{
      '{KIND_SCHEDULE, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_RUN, 4'd0, 32'd0, 1'b0}},
      '{KIND_WAIT, 32'd0, 32'd0, 32'd1, 32'd2, 32'd0, 1'b1,
        '{ST_MISMATCH, 4'd0, 32'd0, 1'b0}},
      '{KIND_WAIT, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd0, 1'b1,
        '{ST_ACCEPTED, 4'd0, 32'd0, 1'b0}},
      '{KIND_SCHEDULE, 32'd7, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_DEADLOCK, 4'd0, 32'd0, 1'b0}},
      '{KIND_WAKE_ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_NONE, 4'd0, 32'd0, 1'b0}},
      '{KIND_WAKE_ALL, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_WOKE, 4'd0, 32'd0, 1'b0}},
      '{KIND_SCHEDULE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_RUN, 4'd0, 32'd0, 1'b0}},
      '{KIND_WAIT, 32'd100, 32'h100, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd5, 1'b0, '0},
      '{KIND_SCHEDULE, 32'd105, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_IDLE, 4'd0, 32'd0, 1'b0}},
      '{KIND_SCHEDULE, 32'd106, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_RUN, 4'd0, 32'd0, 1'b1}},
      '{KIND_SLEEP, 32'hFFFF_FFF0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, '0},
      '{KIND_SCHEDULE, 32'd10, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_IDLE, 4'd0, 32'hFFFF_FFF5, 1'b0}},
      '{KIND_SCHEDULE, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_IDLE, 4'd0, 32'd0, 1'b0}},
      '{KIND_SLEEP, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 1'b1,
        '{ST_ACCEPTED, 4'd0, 32'd0, 1'b0}},
      '{KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 1'b1, '{ST_ACCEPTED, 4'd0, 32'd0, 1'b0}},
      '{KIND_EXIT, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_ACCEPTED, 4'd0, 32'd0, 1'b0}},
      '{KIND_EXIT_ALL, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_ACCEPTED, 4'd0, 32'd0, 1'b0}},
      '{KIND_SCHEDULE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{ST_ALL_EXIT, 4'd0, 32'd0, 1'b0}}
   };

   // main sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_event(directed[i]);

      // phases: table size and handshake pressure
      write_num_tasks(5'd16);
      run_random(300);
      write_num_tasks(5'd5);
      send_idle_pct = 80;
      run_random(250);
      write_num_tasks(5'd0);
      send_idle_pct = 0;
      recv_stall_pct = 80;
      run_random(100);
      write_num_tasks(5'd31);
      send_idle_pct = 26;
      recv_stall_pct = 26;
      run_random(300);
      write_num_tasks(5'd9);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_random(300);

      drain_queue();
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
src/rrts_pkg.sv
src/rrts_ctrl.sv
src/rrts_dp.sv
src/round_robin_task_scheduler_unit.sv
verif/round_robin_task_scheduler_unit_tb.sv
